/* rtl/lis_pkg.sv */
package lis_pkg;

	// Fixed-point formats
	localparam int FRAC_BITS = 24;
	localparam int STATE_W   = FRAC_BITS + 1;
	localparam int COEF_W    = 32;
	localparam int PAR_W     = 16;
	localparam int PROD_W    = 64;
	localparam int QUO_W     = 31;
	localparam int NBITS_W   = 5;

	localparam logic [STATE_W-1:0] ONE      = STATE_W'(64'd1 << FRAC_BITS);
	localparam logic [30:0]        Q30_ONE  = 31'h4000_0000;
	localparam logic [31:0]        LN2_Q30  = 32'd744261118;
	localparam logic [31:0]        SIXTY    = 32'd60;
	localparam logic [3:0]         EXP_TERMS = 4'd13;
	localparam logic [3:0]         LN_TERMS  = 4'd12;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		CFG_SINI       = 3'd0,
		CFG_ALPHA_GAIN = 3'd1,
		CFG_COEF_A     = 3'd2,
		CFG_COEF_B     = 3'd3,
		CFG_COEF_C     = 3'd4,
		CFG_INIT_COND  = 3'd5,
		CFG_PAR_FLOOR  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [STATE_W-1:0] sini;
		logic [COEF_W-1:0]  alpha_gain;
		logic [COEF_W-1:0]  coef_a;
		logic [COEF_W-1:0]  coef_b;
		logic [COEF_W-1:0]  coef_c;
		logic [COEF_W-1:0]  init_conductance;
		logic [PAR_W-1:0]   par_floor;
	} cfg_regs_t;

	typedef struct packed {
		logic               start;
		logic [63:0]        num;
		logic [31:0]        den;
		logic [NBITS_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
		logic [31:0]      rem;
	} div_rsp_t;

	typedef struct packed {
		logic [STATE_W-1:0] induction;
		logic [STATE_W-1:0] equilibrium;
		logic [STATE_W-1:0] state_sixty;
		logic               fault;
	} res_t;

	// Clamp a value to one in Q1.F
	function automatic logic [STATE_W-1:0] sat_one(input logic [63:0] v);
		logic [STATE_W-1:0] r;
		r = (v > 64'(ONE)) ? ONE : v[STATE_W-1:0];
		return r;
	endfunction

endpackage

/* rtl/lis_chan_if.sv */
interface lis_item_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [lis_pkg::PAR_W-1:0] par;

	modport source (output valid, kind, par, input ready);
	modport sink   (input valid, kind, par, output ready);
endinterface

interface lis_res_if;
	logic                        valid;
	logic                        ready;
	logic [lis_pkg::STATE_W-1:0] induction;
	logic [lis_pkg::STATE_W-1:0] equilibrium;
	logic [lis_pkg::STATE_W-1:0] state_sixty;
	logic                        fault;

	modport source (output valid, induction, equilibrium, state_sixty, fault, input ready);
	modport sink   (input valid, induction, equilibrium, state_sixty, fault, output ready);
endinterface

interface lis_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/lis_cfg.sv */
module lis_cfg (
	input  logic              clk,
	input  logic              arst_n,
	lis_cfg_if.sink           cfg,
	output lis_pkg::cfg_regs_t regs
);
	import lis_pkg::*;

	// Writes are always taken
	assign cfg.ready = 1'b1;

	// Register file; an unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.sini             <= '0;
			regs.alpha_gain       <= 32'd16777;
			regs.coef_a           <= 32'd16777;
			regs.coef_b           <= 32'd16777;
			regs.coef_c           <= 32'd16777;
			regs.init_conductance <= 32'd16777;
			regs.par_floor        <= 16'd16;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_SINI:       regs.sini             <= cfg.data[STATE_W-1:0];
				CFG_ALPHA_GAIN: regs.alpha_gain       <= cfg.data;
				CFG_COEF_A:     regs.coef_a           <= cfg.data;
				CFG_COEF_B:     regs.coef_b           <= cfg.data;
				CFG_COEF_C:     regs.coef_c           <= cfg.data;
				CFG_INIT_COND:  regs.init_conductance <= cfg.data;
				CFG_PAR_FLOOR:  regs.par_floor        <= cfg.data[PAR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/lis_div.sv */
module lis_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lis_pkg::div_req_t req,
	output lis_pkg::div_rsp_t rsp
);
	import lis_pkg::*;

	logic [63:0]        rem_q;
	logic [63:0]        dsh_q;
	logic [QUO_W-1:0]   quo_q;
	logic [NBITS_W-1:0] cnt_q;
	logic               run_q;
	logic               done_q;
	logic               ge;

	// One quotient bit a cycle, most significant first
	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - NBITS_W'(1);
				if (cnt_q == NBITS_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and shifted divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= {32'b0, req.den} << (req.nbits - NBITS_W'(1));
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? rem_q - dsh_q : rem_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q[31:0];

endmodule

/* rtl/lis_core.sv */
module lis_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lis_pkg::cfg_regs_t          cfg_regs,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic                        item_kind,
	input  logic [lis_pkg::PAR_W-1:0]   item_par,
	output logic                        res_valid,
	output lis_pkg::res_t               res,
	input  logic                        res_ack,
	output lis_pkg::div_req_t           div_req,
	input  lis_pkg::div_rsp_t           div_rsp
);
	import lis_pkg::*;

	typedef enum logic [25:0] {
		ST_IDLE   = 26'h0000001,
		ST_MSEQ   = 26'h0000002,
		ST_GSEQ   = 26'h0000004,
		ST_GXB    = 26'h0000008,
		ST_EXP0   = 26'h0000010,
		ST_DIVW   = 26'h0000020,
		ST_EXPK   = 26'h0000040,
		ST_TMUL   = 26'h0000080,
		ST_TDIV   = 26'h0000100,
		ST_TACC   = 26'h0000200,
		ST_EXPEND = 26'h0000400,
		ST_GXC    = 26'h0000800,
		ST_MS60   = 26'h0001000,
		ST_GS60   = 26'h0002000,
		ST_NRM0   = 26'h0004000,
		ST_NORM   = 26'h0008000,
		ST_ZGOT   = 26'h0010000,
		ST_Z2     = 26'h0020000,
		ST_PMUL   = 26'h0040000,
		ST_PDIV   = 26'h0080000,
		ST_PACC   = 26'h0100000,
		ST_LNE    = 26'h0200000,
		ST_LNS    = 26'h0400000,
		ST_BETA   = 26'h0800000,
		ST_STEP   = 26'h1000000,
		ST_DONE   = 26'h2000000
	} state_t;

	state_t state_q, ret_q;

	logic [STATE_W-1:0] ind_q, seq_q, s60_q;
	logic               fault_q;
	logic [PAR_W-1:0]   par_q;
	logic [43:0]        x_q;
	logic               big_q;
	logic               sel_q;
	logic [5:0]         k_q;
	logic [29:0]        r_q;
	logic [30:0]        term_q;
	logic [31:0]        sum_q;
	logic [3:0]         n_q;
	logic [30:0]        e1_q, e2_q;
	logic [30:0]        m_q;
	logic [4:0]         e_q;
	logic [29:0]        z_q, z2_q, p_q;
	logic [PROD_W-1:0]  prod_q;

	logic [31:0]        ma, mb;
	logic               big;
	logic [30:0]        e_w;
	logic [STATE_W-1:0] s60_w;
	logic               fault_w;
	logic               up;
	logic [STATE_W-1:0] diff;
	logic [STATE_W-1:0] step;
	logic [35:0]        nl;
	logic [30:0]        m_gap;

	assign big     = x_q >= (44'd32 << FRAC_BITS);
	assign e_w     = big_q ? 31'd0 : 31'(sum_q >> k_q);
	assign s60_w   = sat_one({30'b0, prod_q[63:30]});
	assign fault_w = (seq_q == '0) || (s60_w >= seq_q);
	assign up      = seq_q >= ind_q;
	assign diff    = up ? seq_q - ind_q : ind_q - seq_q;
	assign step    = prod_q[54:30];
	assign nl      = 36'({sum_q, 1'b0}) + prod_q[35:0];
	assign m_gap   = Q30_ONE - m_q;

	// Shared multiplier operands and divider requests
	always_comb begin
		ma      = '0;
		mb      = '0;
		div_req = '0;
		case (state_q)
			ST_MSEQ: begin
				ma = cfg_regs.alpha_gain;
				mb = 32'(par_q);
			end
			ST_GSEQ: begin
				ma = cfg_regs.coef_b;
				mb = 32'(par_q);
			end
			ST_EXP0: begin
				if (!big) begin
					div_req.start = 1'b1;
					div_req.num   = 64'(x_q) << (30 - FRAC_BITS);
					div_req.den   = LN2_Q30;
					div_req.nbits = NBITS_W'(6);
				end
			end
			ST_TMUL: begin
				ma = 32'(term_q);
				mb = 32'(r_q);
			end
			ST_TDIV: begin
				div_req.start = 1'b1;
				div_req.num   = 64'(prod_q[59:30]);
				div_req.den   = 32'(n_q);
				div_req.nbits = NBITS_W'(30);
			end
			ST_EXPEND: begin
				if (!sel_q) begin
					ma = cfg_regs.coef_c;
					mb = cfg_regs.init_conductance;
				end else begin
					ma = cfg_regs.coef_a;
					mb = 32'(Q30_ONE - e1_q);
				end
			end
			ST_MS60: begin
				ma = prod_q[61:30];
				mb = 32'(Q30_ONE - e2_q);
			end
			ST_GS60: begin
				if (!fault_w) begin
					div_req.start = 1'b1;
					div_req.num   = 64'(seq_q - s60_w) << 30;
					div_req.den   = 32'(seq_q);
					div_req.nbits = NBITS_W'(31);
				end
			end
			ST_NORM: begin
				if (m_q[30] || m_q[29]) begin
					div_req.start = 1'b1;
					div_req.num   = 64'(m_gap) << 30;
					div_req.den   = 32'(Q30_ONE) + 32'(m_q);
					div_req.nbits = NBITS_W'(30);
				end
			end
			ST_ZGOT: begin
				ma = 32'(div_rsp.quo[29:0]);
				mb = 32'(div_rsp.quo[29:0]);
			end
			ST_PMUL: begin
				ma = 32'(p_q);
				mb = 32'(z2_q);
			end
			ST_PDIV: begin
				div_req.start = 1'b1;
				div_req.num   = 64'(prod_q[59:30]);
				div_req.den   = 32'({n_q, 1'b1});
				div_req.nbits = NBITS_W'(30);
			end
			ST_LNE: begin
				ma = 32'(e_q);
				mb = LN2_Q30;
			end
			ST_LNS: begin
				div_req.start = 1'b1;
				div_req.num   = 64'(nl);
				div_req.den   = SIXTY;
				div_req.nbits = NBITS_W'(30);
			end
			ST_BETA: begin
				ma = 32'(diff);
				mb = 32'(div_rsp.quo);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(ma) * 64'(mb);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			ind_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item_kind) begin
							ind_q   <= sat_one(64'(cfg_regs.sini));
							seq_q   <= sat_one(64'(cfg_regs.sini));
							s60_q   <= '0;
							fault_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							par_q   <= (item_par == '0) ? cfg_regs.par_floor : item_par;
							state_q <= ST_MSEQ;
						end
					end
				end
				ST_MSEQ: state_q <= ST_GSEQ;
				ST_GSEQ: begin
					seq_q   <= sat_one(64'(prod_q[47:4]));
					state_q <= ST_GXB;
				end
				ST_GXB: begin
					x_q     <= prod_q[47:4];
					sel_q   <= 1'b0;
					state_q <= ST_EXP0;
				end
				ST_EXP0: begin
					big_q <= big;
					if (big) begin
						state_q <= ST_EXPEND;
					end else begin
						ret_q   <= ST_EXPK;
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_rsp.done) begin
						state_q <= ret_q;
					end
				end
				ST_EXPK: begin
					k_q     <= div_rsp.quo[5:0];
					r_q     <= div_rsp.rem[29:0];
					term_q  <= Q30_ONE;
					sum_q   <= 32'(Q30_ONE);
					n_q     <= 4'd1;
					state_q <= ST_TMUL;
				end
				ST_TMUL: state_q <= ST_TDIV;
				ST_TDIV: begin
					ret_q   <= ST_TACC;
					state_q <= ST_DIVW;
				end
				ST_TACC: begin
					term_q <= div_rsp.quo;
					// odd terms subtract, even terms add
					sum_q  <= n_q[0] ? sum_q - 32'(div_rsp.quo) : sum_q + 32'(div_rsp.quo);
					if (n_q == EXP_TERMS) begin
						state_q <= ST_EXPEND;
					end else begin
						n_q     <= n_q + 4'd1;
						state_q <= ST_TMUL;
					end
				end
				ST_EXPEND: begin
					if (!sel_q) begin
						e1_q    <= e_w;
						state_q <= ST_GXC;
					end else begin
						e2_q    <= e_w;
						state_q <= ST_MS60;
					end
				end
				ST_GXC: begin
					x_q     <= 44'(prod_q[63:FRAC_BITS]);
					sel_q   <= 1'b1;
					state_q <= ST_EXP0;
				end
				ST_MS60: state_q <= ST_GS60;
				ST_GS60: begin
					s60_q   <= s60_w;
					fault_q <= fault_w;
					if (fault_w) begin
						state_q <= ST_DONE;
					end else begin
						ret_q   <= ST_NRM0;
						state_q <= ST_DIVW;
					end
				end
				ST_NRM0: begin
					m_q     <= div_rsp.quo;
					e_q     <= '0;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					// normalise into [0.5, 1]
					if (m_q[30] || m_q[29]) begin
						ret_q   <= ST_ZGOT;
						state_q <= ST_DIVW;
					end else begin
						m_q <= {m_q[29:0], 1'b0};
						e_q <= e_q + 5'd1;
					end
				end
				ST_ZGOT: begin
					z_q     <= div_rsp.quo[29:0];
					state_q <= ST_Z2;
				end
				ST_Z2: begin
					z2_q    <= prod_q[59:30];
					p_q     <= z_q;
					sum_q   <= 32'(z_q);
					n_q     <= 4'd1;
					state_q <= ST_PMUL;
				end
				ST_PMUL: state_q <= ST_PDIV;
				ST_PDIV: begin
					p_q     <= prod_q[59:30];
					ret_q   <= ST_PACC;
					state_q <= ST_DIVW;
				end
				ST_PACC: begin
					sum_q <= sum_q + 32'(div_rsp.quo);
					if (n_q == LN_TERMS) begin
						state_q <= ST_LNE;
					end else begin
						n_q     <= n_q + 4'd1;
						state_q <= ST_PMUL;
					end
				end
				ST_LNE: state_q <= ST_LNS;
				ST_LNS: begin
					ret_q   <= ST_BETA;
					state_q <= ST_DIVW;
				end
				ST_BETA: state_q <= ST_STEP;
				ST_STEP: begin
					// move towards equilibrium, clamped to [0, 1]
					if (up) begin
						ind_q <= sat_one(64'(ind_q) + 64'(step));
					end else begin
						ind_q <= (step > ind_q) ? '0 : ind_q - step;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_ready      = state_q == ST_IDLE;
	assign res_valid       = state_q == ST_DONE;
	assign res.induction   = ind_q;
	assign res.equilibrium = seq_q;
	assign res.state_sixty = s60_q;
	assign res.fault       = fault_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIVW)
		else $error("divider finished outside its wait state");

	a_state_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ind_q <= ONE)
		else $error("induction state above one");

	a_fault_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GS60 && fault_w) |=> ($stable(ind_q) && fault_q))
		else $error("faulted tick moved the induction state");

endmodule

/* rtl/leaf_induction_state_step_unit.sv */
// Leaf induction state stepper.
// Channels: item (kind, par) in, result (induction, equilibrium, state_sixty,
// fault) out, and a register write port cfg (index, data), all valid/ready.
// A beat moves on a rising edge with valid and ready high. cfg is always
// ready; write it only while the block is idle.
// Rate: one item at a time; item.ready is high only while idle. A restart
// beat goes straight to the done state and then into the output register.
// A tick runs two exponentials (13-term series), a divide, a log (12-term
// series) and the state update through one 32x32 multiplier and one
// radix-2 divider that gives one quotient bit a cycle. An exponent argument
// large enough to give zero skips its series, and a faulted tick skips the
// log and the state update.
// The result sits in an output register: the sequencer hands it over and is
// ready for the next item while the receiver stalls, and holds only when
// that register is still full.
// Reset clears the induction state to zero and loads register defaults.
module leaf_induction_state_step_unit (
	input  logic      clk,
	input  logic      arst_n,
	lis_item_if.sink  item,
	lis_res_if.source result,
	lis_cfg_if.sink   cfg
);
	import lis_pkg::*;

	cfg_regs_t regs;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	res_t      core_res;
	res_t      out_q;
	logic      core_valid;
	logic      take;
	logic      out_valid_q;

	lis_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lis_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (regs),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.item_kind  (item.kind),
		.item_par   (item.par),
		.res_valid  (core_valid),
		.res        (core_res),
		.res_ack    (take),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

	// Load the output register when it is empty or being drained
	assign take = core_valid && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= core_res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.induction   = out_q.induction;
	assign result.equilibrium = out_q.equilibrium;
	assign result.state_sixty = out_q.state_sixty;
	assign result.fault       = out_q.fault;

endmodule
